// ----- sv/utf8_control_escaper_top_macros.svh -----
// ---------------------------------------------------------------------------
// utf8_control_escaper_top assertion macros
// Clocked assertion shorthands shared by the escaper modules.
// ---------------------------------------------------------------------------
`ifndef UTF8_CONTROL_ESCAPER_TOP_MACROS_SVH
`define UTF8_CONTROL_ESCAPER_TOP_MACROS_SVH

// Same-cycle implication on clk, disabled during reset.
`define UTF8E_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled during reset.
`define UTF8E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/utf8e_pkg.sv -----
// ---------------------------------------------------------------------------
// utf8e_pkg
// Types, byte classes, code point limits and the format-character ROM.
// ---------------------------------------------------------------------------
package utf8e_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_DECIDE
	} top_state_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_LOAD,
		EM_EMIT
	} emit_state_t;

	// One output unit: a raw byte (val[7:0]) or a \u escape of val.
	typedef struct packed {
		logic        esc;
		logic [20:0] val;
	} item_t;

	localparam int MAX_ITEMS = 4;

	typedef struct packed {
		logic                        valid;
		logic [2:0]                  count;
		logic                        eot;
		item_t [MAX_ITEMS-1:0]       items;
	} load_t;

	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [7:0] ASCII_DEL = 8'h7F;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] SURR_LO      = 21'h00D800;
	localparam logic [20:0] SURR_HI      = 21'h00DFFF;
	localparam logic [20:0] ESC_BYTE_BASE = 21'h00DC00;
	localparam logic [20:0] MIN_LEN2     = 21'h000080;
	localparam logic [20:0] MIN_LEN3     = 21'h000800;
	localparam logic [20:0] MIN_LEN4     = 21'h010000;
	localparam logic [20:0] CTRL_LIMIT   = 21'h000020;
	localparam logic [20:0] C1_LO        = 21'h00007F;
	localparam logic [20:0] C1_HI        = 21'h00009F;
	localparam logic [20:0] LINE_SEP     = 21'h002028;
	localparam logic [20:0] PARA_SEP     = 21'h002029;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_HEX_A  = 8'h57;   // 'a' - 10

	localparam int FMT_RANGE_COUNT = 21;

	localparam logic [20:0] FMT_FIRST [FMT_RANGE_COUNT] = '{
		21'h000AD, 21'h00600, 21'h0061C, 21'h006DD, 21'h0070F, 21'h00890,
		21'h008E2, 21'h0180E, 21'h0200B, 21'h0202A, 21'h02060, 21'h02066,
		21'h0FEFF, 21'h0FFF9, 21'h110BD, 21'h110CD, 21'h13430, 21'h1BCA0,
		21'h1D173, 21'hE0001, 21'hE0020
	};

	localparam logic [20:0] FMT_LAST [FMT_RANGE_COUNT] = '{
		21'h000AD, 21'h00605, 21'h0061C, 21'h006DD, 21'h0070F, 21'h00891,
		21'h008E2, 21'h0180E, 21'h0200F, 21'h0202E, 21'h02064, 21'h0206F,
		21'h0FEFF, 21'h0FFFB, 21'h110BD, 21'h110CD, 21'h1343F, 21'h1BCA3,
		21'h1D17A, 21'hE0001, 21'hE007F
	};

	function automatic logic is_hidden(input logic [20:0] cp);
		logic hit;
		hit = (cp < CTRL_LIMIT) || (cp >= C1_LO && cp <= C1_HI) ||
		      (cp == LINE_SEP) || (cp == PARA_SEP);
		for (int i = 0; i < FMT_RANGE_COUNT; i++) begin
			if (cp >= FMT_FIRST[i] && cp <= FMT_LAST[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ----- sv/utf8e_in_if.sv -----
// ---------------------------------------------------------------------------
// utf8e_in_if
// Raw text byte channel: valid/ready with byte and end-of-text mark.
// ---------------------------------------------------------------------------
interface utf8e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ----- sv/utf8e_out_if.sv -----
// ---------------------------------------------------------------------------
// utf8e_out_if
// Sanitized byte channel: valid/ready with byte and run/text end marks.
// ---------------------------------------------------------------------------
interface utf8e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       text_done;

	modport source (output valid, output out_byte, output last_of_run,
		output text_done, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input text_done, output ready);
endinterface

// ----- sv/utf8_control_escaper_top.sv -----
// ---------------------------------------------------------------------------
// utf8_control_escaper_top
// UTF-8 sanitizer: copies well-formed visible text, escapes hidden code
// points as \u plus 4 to 6 hex digits, broken-sequence bytes as \udcXX.
// ---------------------------------------------------------------------------
// Usage: feed raw bytes on raw, marking the last byte of a text with
// end_of_text; read sanitized bytes on clean. An input byte is transferred,
// then decoded; each output unit it releases is loaded, then sent byte by
// byte, where a unit is one copied byte or an escape of 6 to 8 bytes. The
// single output sequencer sends one byte per cycle while clean takes them,
// pausing to load each unit and stalling while clean is not ready. A byte
// may produce no output (pending multi-byte sequence) or up to 24 bytes.
// The next byte is taken once the final output byte sits in the output
// register, even if clean has not yet taken it.
// ---------------------------------------------------------------------------
`include "utf8_control_escaper_top_macros.svh"

module utf8_control_escaper_top (
	input  logic        clk,
	input  logic        arst_n,
	utf8e_in_if.sink    raw,
	utf8e_out_if.source clean
);

	utf8e_pkg::top_state_t st_q, st_d;

	logic [7:0]  byte_q;
	logic        eot_q;
	logic [1:0]  pc_q, pc_d;
	logic [2:0]  el_q, el_d;
	logic [20:0] pv_q, pv_d;
	logic [7:0]  pb_q [3];
	logic [7:0]  pb_d [3];

	logic [20:0] v_d;
	logic [20:0] vmin;
	logic        cont;
	logic        extend;
	logic        bad;
	logic        em_busy;
	logic        xfer;
	logic [2:0]  cnt_d;
	utf8e_pkg::item_t [utf8e_pkg::MAX_ITEMS-1:0] it_d;
	utf8e_pkg::load_t ld;

	assign xfer = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= utf8e_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		raw.ready = 1'b0;
		case (st_q)
			utf8e_pkg::ST_IDLE: begin
				raw.ready = !em_busy;
				if (raw.valid && !em_busy) begin
					st_d = utf8e_pkg::ST_DECIDE;
				end
			end
			utf8e_pkg::ST_DECIDE: begin
				st_d = utf8e_pkg::ST_IDLE;
			end
			default: begin
				st_d = utf8e_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			el_q <= '0;
			pv_q <= '0;
		end else if (st_q == utf8e_pkg::ST_DECIDE) begin
			pc_q <= pc_d;
			el_q <= el_d;
			pv_q <= pv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			byte_q <= raw.data_byte;
			eot_q  <= raw.end_of_text;
		end
		if (st_q == utf8e_pkg::ST_DECIDE) begin
			pb_q <= pb_d;
		end
	end

	assign v_d    = {pv_q[14:0], byte_q[5:0]};
	assign cont   = (byte_q[7:6] == 2'b10);
	assign extend = ((3'({1'b0, pc_q}) + 3'd1) < el_q) && (pc_q != 2'd3);
	assign vmin   = (el_q == 3'd2) ? utf8e_pkg::MIN_LEN2 :
	                (el_q == 3'd3) ? utf8e_pkg::MIN_LEN3 : utf8e_pkg::MIN_LEN4;
	assign bad    = (v_d < vmin) || (v_d > utf8e_pkg::CP_MAX) ||
	                (v_d >= utf8e_pkg::SURR_LO && v_d <= utf8e_pkg::SURR_HI);

	// Build the unit list for the held byte and the next sequence state.
	always_comb begin
		cnt_d = '0;
		it_d  = '0;
		pc_d  = pc_q;
		el_d  = el_q;
		pv_d  = pv_q;
		pb_d  = pb_q;

		if (pc_q == 2'd0 || !cont) begin
			// Escape the broken sequence, then treat the byte as a new lead.
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < pc_q) begin
					it_d[cnt_d[1:0]].esc = 1'b1;
					it_d[cnt_d[1:0]].val = utf8e_pkg::ESC_BYTE_BASE + 21'(pb_q[i]);
					cnt_d = cnt_d + 3'd1;
				end
			end
			pc_d = '0;
			el_d = '0;
			pv_d = '0;
			if (!byte_q[7]) begin
				it_d[cnt_d[1:0]].esc = (byte_q < utf8e_pkg::ASCII_SPACE) ||
				                       (byte_q == utf8e_pkg::ASCII_DEL);
				it_d[cnt_d[1:0]].val = 21'(byte_q);
				cnt_d = cnt_d + 3'd1;
			end else if (byte_q >= utf8e_pkg::LEAD2_MIN && byte_q <= utf8e_pkg::LEAD2_MAX) begin
				el_d    = 3'd2;
				pv_d    = 21'(byte_q[4:0]);
				pb_d[0] = byte_q;
				pc_d    = 2'd1;
			end else if (byte_q >= utf8e_pkg::LEAD3_MIN && byte_q <= utf8e_pkg::LEAD3_MAX) begin
				el_d    = 3'd3;
				pv_d    = 21'(byte_q[3:0]);
				pb_d[0] = byte_q;
				pc_d    = 2'd1;
			end else if (byte_q >= utf8e_pkg::LEAD4_MIN && byte_q <= utf8e_pkg::LEAD4_MAX) begin
				el_d    = 3'd4;
				pv_d    = 21'(byte_q[2:0]);
				pb_d[0] = byte_q;
				pc_d    = 2'd1;
			end else begin
				it_d[cnt_d[1:0]].esc = 1'b1;
				it_d[cnt_d[1:0]].val = utf8e_pkg::ESC_BYTE_BASE + 21'(byte_q);
				cnt_d = cnt_d + 3'd1;
			end
		end else if (extend) begin
			pb_d[pc_q] = byte_q;
			pc_d       = pc_q + 2'd1;
			pv_d       = v_d;
		end else begin
			if (bad) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < pc_q) begin
						it_d[cnt_d[1:0]].esc = 1'b1;
						it_d[cnt_d[1:0]].val = utf8e_pkg::ESC_BYTE_BASE + 21'(pb_q[i]);
						cnt_d = cnt_d + 3'd1;
					end
				end
				it_d[cnt_d[1:0]].esc = 1'b1;
				it_d[cnt_d[1:0]].val = utf8e_pkg::ESC_BYTE_BASE + 21'(byte_q);
				cnt_d = cnt_d + 3'd1;
			end else if (utf8e_pkg::is_hidden(v_d)) begin
				it_d[cnt_d[1:0]].esc = 1'b1;
				it_d[cnt_d[1:0]].val = v_d;
				cnt_d = cnt_d + 3'd1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < pc_q) begin
						it_d[cnt_d[1:0]].esc = 1'b0;
						it_d[cnt_d[1:0]].val = 21'(pb_q[i]);
						cnt_d = cnt_d + 3'd1;
					end
				end
				it_d[cnt_d[1:0]].esc = 1'b0;
				it_d[cnt_d[1:0]].val = 21'(byte_q);
				cnt_d = cnt_d + 3'd1;
			end
			pc_d = '0;
			el_d = '0;
			pv_d = '0;
		end

		// Text ends with a sequence still open: escape what is left.
		if (eot_q && pc_d != 2'd0) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < pc_d) begin
					it_d[cnt_d[1:0]].esc = 1'b1;
					it_d[cnt_d[1:0]].val = utf8e_pkg::ESC_BYTE_BASE + 21'(pb_d[i]);
					cnt_d = cnt_d + 3'd1;
				end
			end
			pc_d = '0;
			el_d = '0;
			pv_d = '0;
		end
	end

	assign ld.valid = (st_q == utf8e_pkg::ST_DECIDE) && (cnt_d != 3'd0);
	assign ld.count = cnt_d;
	assign ld.eot   = eot_q;
	assign ld.items = it_d;

	utf8e_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.busy   (em_busy),
		.clean  (clean)
	);

	`UTF8E_ASSERT_NEXT(a_accept_decide, xfer, st_q == utf8e_pkg::ST_DECIDE, "no decode after transfer")
	`UTF8E_ASSERT_IMPLIES(a_pending_short, pc_q != 2'd0, el_q > 3'(pc_q), "pending count reached length")
	`UTF8E_ASSERT_NEXT(a_eot_clears, (st_q == utf8e_pkg::ST_DECIDE) && eot_q, pc_q == 2'd0, "sequence left open at text end")

endmodule

// ----- sv/utf8e_emitter.sv -----
// ---------------------------------------------------------------------------
// utf8e_emitter
// Output sequencer: loads each of up to four units, then sends one byte per
// cycle when clean has room, expanding escapes via a nibble shift register.
// ---------------------------------------------------------------------------
`include "utf8_control_escaper_top_macros.svh"

module utf8e_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8e_pkg::load_t    ld,
	output logic                busy,
	utf8e_out_if.source         clean
);

	utf8e_pkg::emit_state_t st_q, st_d;

	utf8e_pkg::item_t [utf8e_pkg::MAX_ITEMS-1:0] it_q, it_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        eot_q, eot_d;
	logic [1:0]  ip_q, ip_d;
	logic [2:0]  pos_q, pos_d;
	logic [3:0]  len_q, len_d;
	logic [23:0] sh_q, sh_d;

	logic        out_valid_q, out_valid_d;
	logic [7:0]  out_byte_q, out_byte_d;
	logic        out_last_q, out_last_d;
	logic        out_done_q, out_done_d;

	utf8e_pkg::item_t cur;
	logic             room;
	logic             last_item;
	logic             last_run;
	logic [3:0]       nib;

	assign cur       = it_q[ip_q];
	assign room      = !out_valid_q || clean.ready;
	assign last_item = (4'({1'b0, pos_q}) + 4'd1) == len_q;
	assign last_run  = last_item && ((3'({1'b0, ip_q}) + 3'd1) == cnt_q);
	assign nib       = sh_q[23:20];
	assign busy      = (st_q != utf8e_pkg::EM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= utf8e_pkg::EM_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ip_q        <= ip_d;
			pos_q       <= pos_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		it_q       <= it_d;
		cnt_q      <= cnt_d;
		eot_q      <= eot_d;
		len_q      <= len_d;
		sh_q       <= sh_d;
		out_byte_q <= out_byte_d;
		out_last_q <= out_last_d;
		out_done_q <= out_done_d;
	end

	always_comb begin
		st_d        = st_q;
		it_d        = it_q;
		cnt_d       = cnt_q;
		eot_d       = eot_q;
		ip_d        = ip_q;
		pos_d       = pos_q;
		len_d       = len_q;
		sh_d        = sh_q;
		out_byte_d  = out_byte_q;
		out_last_d  = out_last_q;
		out_done_d  = out_done_q;
		out_valid_d = out_valid_q && !clean.ready;

		case (st_q)
			utf8e_pkg::EM_IDLE: begin
				if (ld.valid) begin
					it_d  = ld.items;
					cnt_d = ld.count;
					eot_d = ld.eot;
					ip_d  = '0;
					st_d  = utf8e_pkg::EM_LOAD;
				end
			end
			utf8e_pkg::EM_LOAD: begin
				// Size the unit and left-align its leading hex digit.
				pos_d = '0;
				if (!cur.esc) begin
					len_d = 4'd1;
					sh_d  = '0;
				end else if (cur.val[20]) begin
					len_d = 4'd8;
					sh_d  = {3'b000, cur.val};
				end else if (cur.val[19:16] != 4'd0) begin
					len_d = 4'd7;
					sh_d  = {cur.val[19:0], 4'd0};
				end else begin
					len_d = 4'd6;
					sh_d  = {cur.val[15:0], 8'd0};
				end
				st_d = utf8e_pkg::EM_EMIT;
			end
			utf8e_pkg::EM_EMIT: begin
				if (room) begin
					out_valid_d = 1'b1;
					out_last_d  = last_run;
					out_done_d  = last_run && eot_q;
					if (!cur.esc) begin
						out_byte_d = cur.val[7:0];
					end else if (pos_q == 3'd0) begin
						out_byte_d = utf8e_pkg::CH_BSLASH;
					end else if (pos_q == 3'd1) begin
						out_byte_d = utf8e_pkg::CH_U;
					end else begin
						out_byte_d = (nib < 4'd10) ? (utf8e_pkg::CH_ZERO + 8'(nib))
						                           : (utf8e_pkg::CH_HEX_A + 8'(nib));
						sh_d = {sh_q[19:0], 4'd0};
					end
					if (last_run) begin
						st_d = utf8e_pkg::EM_IDLE;
					end else if (last_item) begin
						ip_d = ip_q + 2'd1;
						st_d = utf8e_pkg::EM_LOAD;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
			end
			default: begin
				st_d = utf8e_pkg::EM_IDLE;
			end
		endcase
	end

	assign clean.valid       = out_valid_q;
	assign clean.out_byte    = out_byte_q;
	assign clean.last_of_run = out_last_q;
	assign clean.text_done   = out_done_q;

	`UTF8E_ASSERT_IMPLIES(a_load_when_idle, ld.valid, st_q == utf8e_pkg::EM_IDLE, "load while busy")
	`UTF8E_ASSERT_IMPLIES(a_load_count, ld.valid, (ld.count != 3'd0) && (ld.count <= 3'd4), "bad unit count")
	`UTF8E_ASSERT_IMPLIES(a_pos_in_unit, st_q == utf8e_pkg::EM_EMIT, 4'(pos_q) < len_q, "position past unit")
	`UTF8E_ASSERT_IMPLIES(a_done_is_last, out_valid_q && out_done_q, out_last_q, "text end without run end")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_control_escaper_top. Raw text bytes go in on
// the raw channel with random gaps. A byte-level decoder model in the bench
// predicts the sanitized bytes, and every transfer on the clean channel is
// checked in order against them. The clean side stalls at random.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int TAIL_CYCLES   = 40;
	localparam int RANDOM_ITEMS  = 105;
	localparam int REPORT_LIMIT  = 10;

	localparam logic [7:0]  BACKSLASH  = 8'h5C;
	localparam logic [7:0]  LETTER_U   = 8'h75;
	localparam logic [7:0]  DIGIT_ZERO = 8'h30;
	localparam logic [7:0]  LETTER_A   = 8'h61;
	localparam logic [20:0] BYTE_ESC_BASE = 21'h00DC00;
	localparam logic [20:0] TOP_POINT  = 21'h10FFFF;
	localparam logic [20:0] SURROGATE_LO = 21'h00D800;
	localparam logic [20:0] SURROGATE_HI = 21'h00DFFF;
	localparam logic [20:0] LINE_BREAK_CP = 21'h002028;

	localparam int FORMAT_SPANS = 21;
	localparam logic [20:0] FORMAT_LO [FORMAT_SPANS] = '{
		21'h000AD, 21'h00600, 21'h0061C, 21'h006DD, 21'h0070F, 21'h00890,
		21'h008E2, 21'h0180E, 21'h0200B, 21'h0202A, 21'h02060, 21'h02066,
		21'h0FEFF, 21'h0FFF9, 21'h110BD, 21'h110CD, 21'h13430, 21'h1BCA0,
		21'h1D173, 21'hE0001, 21'hE0020
	};
	localparam logic [20:0] FORMAT_HI [FORMAT_SPANS] = '{
		21'h000AD, 21'h00605, 21'h0061C, 21'h006DD, 21'h0070F, 21'h00891,
		21'h008E2, 21'h0180E, 21'h0200F, 21'h0202E, 21'h02064, 21'h0206F,
		21'h0FEFF, 21'h0FFFB, 21'h110BD, 21'h110CD, 21'h1343F, 21'h1BCA3,
		21'h1D17A, 21'hE0001, 21'hE007F
	};

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       done;
	} clean_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	utf8e_in_if  raw ();
	utf8e_out_if clean ();

	utf8_control_escaper_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.clean  (clean)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	clean_beat_t expected_clean_q[$];
	clean_beat_t run_q[$];
	clean_beat_t seen_beat;
	clean_beat_t want_beat;

	// decoder state of the prediction
	logic [7:0]  seq_bytes [3];
	int          seq_count = 0;
	int          seq_len = 0;
	logic [20:0] seq_value = '0;

	int fail_count = 0;
	int items_sent = 0;
	int cycles = 0;
	bit calm = 1'b0;

	// ---------------------------------------------------------------- model
	function automatic bit needs_escape(input logic [20:0] cp);
		bit hit;
		hit = (cp < 21'h20) || (cp >= 21'h7F && cp <= 21'h9F) ||
		      (cp == LINE_BREAK_CP) || (cp == LINE_BREAK_CP + 21'd1);
		foreach (FORMAT_LO[i]) begin
			if (cp >= FORMAT_LO[i] && cp <= FORMAT_HI[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic void emit_char(input logic [7:0] c);
		clean_beat_t beat;
		beat.b = c;
		beat.last = 1'b0;
		beat.done = 1'b0;
		run_q = {run_q, beat};
	endfunction

	function automatic void emit_escape(input logic [20:0] cp);
		int digits;
		logic [3:0] nib;
		digits = 4;
		if (cp > 21'h0FFFF) digits = 5;
		if (cp > 21'hFFFFF) digits = 6;
		emit_char(BACKSLASH);
		emit_char(LETTER_U);
		for (int i = digits - 1; i >= 0; i--) begin
			nib = 4'(cp >> (4 * i));
			emit_char(nib < 4'd10 ? DIGIT_ZERO + 8'(nib) : LETTER_A + 8'(nib) - 8'd10);
		end
	endfunction

	// escape every held byte and drop the sequence
	function automatic void flush_sequence();
		for (int i = 0; i < seq_count; i++) begin
			emit_escape(BYTE_ESC_BASE + 21'(seq_bytes[i]));
		end
		seq_count = 0;
		seq_len = 0;
		seq_value = '0;
	endfunction

	function automatic void open_sequence(input logic [7:0] b);
		int len;
		len = 0;
		if (b >= 8'hC2 && b <= 8'hDF) len = 2;
		else if (b >= 8'hE0 && b <= 8'hEF) len = 3;
		else if (b >= 8'hF0 && b <= 8'hF4) len = 4;
		if (b < 8'h80) begin
			if (needs_escape(21'(b))) emit_escape(21'(b));
			else emit_char(b);
		end else if (len == 0) begin
			emit_escape(BYTE_ESC_BASE + 21'(b));
		end else begin
			seq_len = len;
			seq_value = 21'(b & (8'h7F >> len));
			seq_bytes[0] = b;
			seq_count = 1;
		end
	endfunction

	function automatic void predict_clean(input logic [7:0] b, input logic eot);
		logic [20:0] v;
		logic [20:0] floor_cp;
		run_q.delete();
		if (seq_count == 0) begin
			open_sequence(b);
		end else if (b[7:6] != 2'b10) begin
			flush_sequence();
			open_sequence(b);
		end else begin
			v = {seq_value[14:0], b[5:0]};
			if (seq_count + 1 < seq_len) begin
				seq_bytes[seq_count] = b;
				seq_count++;
				seq_value = v;
			end else begin
				floor_cp = seq_len == 2 ? 21'h80 : seq_len == 3 ? 21'h800 : 21'h10000;
				if (v < floor_cp || v > TOP_POINT || (v >= SURROGATE_LO && v <= SURROGATE_HI)) begin
					flush_sequence();
					emit_escape(BYTE_ESC_BASE + 21'(b));
				end else begin
					if (needs_escape(v)) begin
						emit_escape(v);
					end else begin
						for (int i = 0; i < seq_count; i++) emit_char(seq_bytes[i]);
						emit_char(b);
					end
					seq_count = 0;
					seq_len = 0;
					seq_value = '0;
				end
			end
		end
		if (eot && seq_count != 0) flush_sequence();
		if (run_q.size() > 0) begin
			run_q[$].last = 1'b1;
			run_q[$].done = eot;
		end
		expected_clean_q = {expected_clean_q, run_q};
	endfunction

	// ---------------------------------------------------------------- driving
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	task automatic send_raw(input logic [7:0] b, input logic eot);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			raw.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw.valid <= 1'b1;
		raw.data_byte <= b;
		raw.end_of_text <= eot;
		do @(posedge clk); while (!raw.ready);
		items_sent++;
		predict_clean(b, eot);
	endtask

	task automatic send_code_point(input logic [20:0] cp, input logic eot);
		if (cp < 21'h80) begin
			send_raw(cp[7:0], eot);
		end else if (cp < 21'h800) begin
			send_raw({3'b110, cp[10:6]}, 1'b0);
			send_raw({2'b10, cp[5:0]}, eot);
		end else if (cp < 21'h10000) begin
			send_raw({4'b1110, cp[15:12]}, 1'b0);
			send_raw({2'b10, cp[11:6]}, 1'b0);
			send_raw({2'b10, cp[5:0]}, eot);
		end else begin
			send_raw({5'b11110, cp[20:18]}, 1'b0);
			send_raw({2'b10, cp[17:12]}, 1'b0);
			send_raw({2'b10, cp[11:6]}, 1'b0);
			send_raw({2'b10, cp[5:0]}, eot);
		end
	endtask

	// hold the sender until every predicted byte is out, then let the block settle
	task automatic wait_drained();
		raw.valid <= 1'b0;
		while (expected_clean_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] pick_lead(input int len);
		if (len == 2) return 8'($urandom_range(8'hC2, 8'hDF));
		if (len == 3) return 8'($urandom_range(8'hE0, 8'hEF));
		return 8'($urandom_range(8'hF0, 8'hF4));
	endfunction

	function automatic logic [20:0] pick_hidden();
		int span;
		case ($urandom_range(0, 3))
			0: return 21'($urandom_range(0, 8'h1F));
			1: return 21'($urandom_range(8'h7F, 8'h9F));
			2: return LINE_BREAK_CP + 21'($urandom_range(0, 1));
			default: begin
				span = $urandom_range(0, FORMAT_SPANS - 1);
				return FORMAT_LO[span] + 21'($urandom_range(0, FORMAT_HI[span] - FORMAT_LO[span]));
			end
		endcase
	endfunction

	// one piece of text: mostly well-formed code points, some noise and damage
	task automatic send_text_piece();
		int pick;
		int len;
		int keep;
		logic [20:0] cp;
		logic [7:0] lead;
		logic [7:0] second;
		logic [7:0] breaker;
		logic eot;
		pick = $urandom_range(0, 99);
		eot = ($urandom_range(0, 9) == 0);
		if (pick < 25) begin
			send_raw(8'($urandom_range(0, 127)), eot);
		end else if (pick < 40) begin
			send_code_point(21'($urandom_range(21'h80, 21'h7FF)), eot);
		end else if (pick < 55) begin
			cp = 21'($urandom_range(21'h800, 21'hFFFF));
			if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp -= 21'h1000;
			send_code_point(cp, eot);
		end else if (pick < 65) begin
			send_code_point(21'($urandom_range(21'h10000, TOP_POINT)), eot);
		end else if (pick < 75) begin
			send_code_point(pick_hidden(), eot);
		end else if (pick < 82) begin
			send_raw(8'($urandom_range(0, 255)), eot);
		end else if (pick < 88) begin
			// overlong, surrogate or out of range, caught only when complete
			case ($urandom_range(0, 3))
				0: begin lead = 8'hE0; second = 8'h80 | 8'($urandom_range(0, 31)); end
				1: begin lead = 8'hED; second = 8'hA0 | 8'($urandom_range(0, 31)); end
				2: begin lead = 8'hF0; second = 8'h80 | 8'($urandom_range(0, 15)); end
				default: begin lead = 8'hF4; second = 8'h90 + 8'($urandom_range(0, 47)); end
			endcase
			send_raw(lead, 1'b0);
			send_raw(second, 1'b0);
			if (lead >= 8'hF0) send_raw(pick_cont(), 1'b0);
			send_raw(pick_cont(), eot);
		end else begin
			// sequence cut short: by end of text, by a breaking byte, or by what follows
			len = $urandom_range(2, 4);
			keep = $urandom_range(0, len - 2);
			send_raw(pick_lead(len), keep == 0 && eot);
			for (int k = 1; k <= keep; k++) send_raw(pick_cont(), k == keep && eot);
			if (!eot && pick >= 94) begin
				breaker = 8'($urandom_range(0, 255));
				if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
				send_raw(breaker, $urandom_range(0, 5) == 0);
			end
		end
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_single_bytes();
		send_raw(8'h41, 1'b0);
		send_raw(8'h00, 1'b0);
		send_raw(8'h80, 1'b0);
		send_raw(8'hFF, 1'b1);
	endtask

	task automatic test_hidden_points();
		send_code_point(LINE_BREAK_CP, 1'b0);
		send_code_point(21'hE0001, 1'b1);
	endtask

	task automatic test_bad_values();
		send_raw(8'hE0, 1'b0); send_raw(8'h80, 1'b0); send_raw(8'h80, 1'b0);
		send_raw(8'hED, 1'b0); send_raw(8'hA0, 1'b0); send_raw(8'h80, 1'b0);
		// above the top code point: four byte escapes in one run
		send_raw(8'hF4, 1'b0); send_raw(8'h90, 1'b0); send_raw(8'h80, 1'b0);
		send_raw(8'h80, 1'b1);
	endtask

	task automatic test_broken_and_cut();
		send_raw(8'hE2, 1'b0);
		send_raw(8'h41, 1'b0);
		send_raw(8'hE2, 1'b0);
		send_raw(8'h82, 1'b1);
	endtask

	task automatic test_random_text();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			calm = (items_sent - first > 50) && (items_sent - first < 80);
			send_text_piece();
		end
		calm = 1'b0;
	endtask

	// ---------------------------------------------------------------- checking
	task automatic report_mismatch(input string what, input clean_beat_t want,
		input clean_beat_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
				$time, what, want.b, want.last, want.done, got.b, got.last, got.done);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && clean.valid && clean.ready) begin
			seen_beat.b = clean.out_byte;
			seen_beat.last = clean.last_of_run;
			seen_beat.done = clean.text_done;
			if (expected_clean_q.size() == 0) begin
				report_mismatch("unexpected transfer", '0, seen_beat);
			end else begin
				want_beat = expected_clean_q.pop_front();
				if (seen_beat.b !== want_beat.b || seen_beat.last !== want_beat.last ||
				    seen_beat.done !== want_beat.done) begin
					report_mismatch("mismatch", want_beat, seen_beat);
				end
			end
		end
	end

	// clean side: ready bursts with random stalls
	initial begin
		int gap;
		clean.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				clean.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			clean.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		raw.valid <= 1'b0;
		raw.data_byte <= 8'h00;
		raw.end_of_text <= 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		wait_drained();
		test_hidden_points();
		test_bad_values();
		wait_drained();
		test_broken_and_cut();
		test_random_text();
		wait_drained();
		if (fail_count == 0 && expected_clean_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/utf8e_pkg.sv
sv/utf8e_in_if.sv
sv/utf8e_out_if.sv
sv/utf8e_emitter.sv
sv/utf8_control_escaper_top.sv
sim/tb_top.sv
